[src/c3x3_pkg.sv]
// shared constants for the streaming 3x3 convolution with constant padding
package c3x3_pkg;

  localparam int PIX_W        = 16;
  localparam int WIDTH_REG_W  = 9;
  localparam int HEIGHT_REG_W = 13;
  localparam int COEFF_REG_W  = 48;
  localparam int CFG_INDEX_W  = 3;
  localparam int FRAC_SHIFT   = 12;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int OUT_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_TOP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_MID    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_BOT    = 3'd4;

  localparam logic [WIDTH_REG_W-1:0]  RST_FRAME_WIDTH  = 9'd256;
  localparam logic [HEIGHT_REG_W-1:0] RST_FRAME_HEIGHT = 13'd256;
  localparam logic [COEFF_REG_W-1:0]  RST_COEFF_ROW    = 48'h01C7_01C7_01C7;

  localparam logic signed [PIX_W-1:0] PAD_ONE = 16'sh0100;
  localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

endpackage

[src/conv3x3_stream_const_pad.sv]
// top level: streaming 3x3 convolution over a raster pixel stream with constant padding
//
// Takes one Q8.8 pixel per clock in raster order while in_stall is low and emits Q8.8 results
// with their row and column. The two previous rows sit in one line memory (one entry per
// column, read at accept, written back when the pixel leaves the window stage) and a six-tap
// column window. Results go one per clock while the output queue has room, through a single
// convolution datapath (nine multipliers, row sums, final sum with floor rounding and
// saturation) and its product and row-sum registers into a four-word output queue. A pixel
// holds the input until every result it causes has issued: one in plain positions, two at
// the end of a row and along the last row, four for the final pixel of the frame. Pixels outside
// the frame read as 1.0. The line memory has no reset and needs no clearing pass.
module conv3x3_stream_const_pad #(
  parameter int MAX_WIDTH  = c3x3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = c3x3_pkg::DEF_MAX_HEIGHT,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [c3x3_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [c3x3_pkg::COEFF_REG_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [c3x3_pkg::PIX_W-1:0]    pixel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [c3x3_pkg::PIX_W-1:0]    filtered,
  output logic [ROW_W-1:0]                     out_row,
  output logic [COL_W-1:0]                     out_col,
  output logic                                 last,
  output logic                                 frame_done
);
  import c3x3_pkg::*;

  localparam int CW_C   = ((COL_W > WIDTH_REG_W) ? COL_W : WIDTH_REG_W) + 1;
  localparam int CW_R   = ((ROW_W > HEIGHT_REG_W) ? ROW_W : HEIGHT_REG_W) + 1;
  localparam int PROD_W = 2 * PIX_W;
  localparam int SUM3_W = PROD_W + 2;
  localparam int TOT_W  = PROD_W + 4;
  localparam int SH_W   = TOT_W - FRAC_SHIFT;
  localparam int PTR_W  = $clog2(OUT_DEPTH);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int CRD_W  = $clog2(OUT_DEPTH + 3);

  typedef struct packed {
    logic signed [PIX_W-1:0] filtered;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    last;
    logic                    done;
  } result_t;

  // configuration
  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;
  logic [COEFF_REG_W-1:0]  coeff_top;
  logic [COEFF_REG_W-1:0]  coeff_mid;
  logic [COEFF_REG_W-1:0]  coeff_bot;

  // position of the next input
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic             last_col_in;
  logic             last_row_in;
  logic [3:0]       mask_in;

  // window stage
  logic                    a_valid;
  logic signed [PIX_W-1:0] a_pixel;
  logic [ROW_W-1:0]        a_row;
  logic [COL_W-1:0]        a_col;
  logic                    a_last_row;
  logic                    a_last_col;
  logic [3:0]              a_mask;
  logic [3:0]              mask_rest;
  logic [1:0]              job_sel;
  logic                    can_issue;
  logic                    issue;
  logic                    a_retire;
  logic                    in_accept;

  // line memory: older row in the upper half, newer row in the lower half
  logic [2*PIX_W-1:0]      line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]      line_rd;
  logic                    fwd;
  logic [2*PIX_W-1:0]      fwd_data;
  logic [2*PIX_W-1:0]      line_q;
  logic signed [PIX_W-1:0] above2;
  logic signed [PIX_W-1:0] above1;

  logic signed [PIX_W-1:0] win_cols [6];
  logic signed [PIX_W-1:0] grid [4][4];
  logic signed [PIX_W-1:0] taps [3][3];
  logic signed [PIX_W-1:0] coefs [3][3];
  logic                    row_ge1, row_ge2, col_ge1, col_ge2;

  // convolution pipeline
  logic                     p_valid;
  logic signed [PROD_W-1:0] prod [3][3];
  logic [ROW_W-1:0]         p_row;
  logic [COL_W-1:0]         p_col;
  logic                     p_last;
  logic                     p_done;

  logic                     q_valid;
  logic signed [SUM3_W-1:0] q_sum [3];
  logic [ROW_W-1:0]         q_row;
  logic [COL_W-1:0]         q_col;
  logic                     q_last;
  logic                     q_done;

  logic signed [TOT_W-1:0]  total;
  logic [SH_W-1:0]          shifted;
  logic [SH_W-PIX_W:0]      upper;
  logic signed [PIX_W-1:0]  sat_val;

  // output queue
  result_t          fifo [OUT_DEPTH];
  result_t          head;
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign last_col_in = (CW_C'(col_pos) + CW_C'(1) >= CW_C'(frame_width)) ||
                       (col_pos == COL_W'(MAX_WIDTH - 1));
  assign last_row_in = (CW_R'(row_pos) + CW_R'(1) >= CW_R'(frame_height)) ||
                       (row_pos == ROW_W'(MAX_HEIGHT - 1));

  // bit k set: job k pending, window offset {row, col} = k
  assign mask_in = {last_row_in && last_col_in,
                    last_row_in && (col_pos != '0),
                    (row_pos != '0) && last_col_in,
                    (row_pos != '0) && (col_pos != '0)};

  always_comb begin
    job_sel = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (a_mask[k]) job_sel = 2'(k);
    end
  end

  assign mask_rest = a_mask & ~(4'b0001 << job_sel);
  assign can_issue = (CRD_W'(count) + CRD_W'(p_valid) + CRD_W'(q_valid)) < CRD_W'(OUT_DEPTH);
  assign issue     = a_valid && (a_mask != '0) && can_issue;
  assign a_retire  = a_valid && ((a_mask == '0) || (can_issue && (mask_rest == '0)));
  assign in_stall  = a_valid && !a_retire;
  assign in_accept = in_valid && !in_stall;

  assign line_q = fwd ? fwd_data : line_rd;
  assign above2 = line_q[2*PIX_W-1:PIX_W];
  assign above1 = line_q[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (a_retire) line_mem[a_col] <= {above1, a_pixel};
    if (in_accept) line_rd <= line_mem[col_pos];
  end

  assign row_ge1 = (a_row != '0);
  assign row_ge2 = {1'b0, a_row} >= (ROW_W + 1)'(2);
  assign col_ge1 = (a_col != '0);
  assign col_ge2 = {1'b0, a_col} >= (COL_W + 1)'(2);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      grid[i][0] = win_cols[3+i];
      grid[i][1] = win_cols[i];
    end
    grid[0][2] = above2;
    grid[1][2] = above1;
    grid[2][2] = a_pixel;
    for (int i = 0; i < 4; i++) begin
      grid[i][3] = PAD_ONE;
      grid[3][i] = PAD_ONE;
    end
    for (int j = 0; j < 4; j++) begin
      if (!row_ge2) grid[0][j] = PAD_ONE;
      if (!row_ge1) grid[1][j] = PAD_ONE;
    end
    for (int i = 0; i < 4; i++) begin
      if (!col_ge2) grid[i][0] = PAD_ONE;
      if (!col_ge1) grid[i][1] = PAD_ONE;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (job_sel[1] && job_sel[0]) begin
          taps[i][j] = grid[i+1][j+1];
        end else if (job_sel[1]) begin
          taps[i][j] = grid[i+1][j];
        end else if (job_sel[0]) begin
          taps[i][j] = grid[i][j+1];
        end else begin
          taps[i][j] = grid[i][j];
        end
        coefs[0][j] = coeff_top[PIX_W*j +: PIX_W];
        coefs[1][j] = coeff_mid[PIX_W*j +: PIX_W];
        coefs[2][j] = coeff_bot[PIX_W*j +: PIX_W];
      end
    end
  end

  // floor to Q8.8 and saturate
  assign total   = TOT_W'(q_sum[0]) + TOT_W'(q_sum[1]) + TOT_W'(q_sum[2]);
  assign shifted = total[TOT_W-1:FRAC_SHIFT];
  assign upper   = shifted[SH_W-1:PIX_W-1];

  always_comb begin
    if ((upper == '0) || (upper == '1)) begin
      sat_val = shifted[PIX_W-1:0];
    end else if (shifted[SH_W-1]) begin
      sat_val = PIX_MIN;
    end else begin
      sat_val = PIX_MAX;
    end
  end

  assign push      = q_valid;
  assign pop       = out_valid && !out_stall;
  assign head      = fifo[rptr];
  assign out_valid = (count != '0);
  assign filtered  = head.filtered;
  assign out_row   = head.row;
  assign out_col   = head.col;
  assign last      = head.last;
  assign frame_done = head.done;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      coeff_top    <= RST_COEFF_ROW;
      coeff_mid    <= RST_COEFF_ROW;
      coeff_bot    <= RST_COEFF_ROW;
      col_pos      <= '0;
      row_pos      <= '0;
      a_valid      <= 1'b0;
      a_mask       <= '0;
      fwd          <= 1'b0;
      p_valid      <= 1'b0;
      q_valid      <= 1'b0;
      wptr         <= '0;
      rptr         <= '0;
      count        <= '0;
      for (int i = 0; i < 6; i++) win_cols[i] <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_REG_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_REG_W-1:0];
          REG_COEFF_TOP:    coeff_top    <= cfg_data;
          REG_COEFF_MID:    coeff_mid    <= cfg_data;
          REG_COEFF_BOT:    coeff_bot    <= cfg_data;
          default: ;
        endcase
      end

      if (in_accept) begin
        if (last_col_in) begin
          col_pos <= '0;
          row_pos <= last_row_in ? '0 : row_pos + ROW_W'(1);
        end else begin
          col_pos <= col_pos + COL_W'(1);
        end
        fwd <= a_retire && (a_col == col_pos);
      end

      if (in_accept) begin
        a_valid <= 1'b1;
        a_mask  <= mask_in;
      end else if (a_retire) begin
        a_valid <= 1'b0;
        a_mask  <= '0;
      end else if (issue) begin
        a_mask  <= mask_rest;
      end

      if (a_retire) begin
        for (int i = 0; i < 3; i++) win_cols[3+i] <= win_cols[i];
        win_cols[0] <= above2;
        win_cols[1] <= above1;
        win_cols[2] <= a_pixel;
      end

      p_valid <= issue;
      q_valid <= p_valid;

      if (push) wptr <= wptr + PTR_W'(1);
      if (pop) rptr <= rptr + PTR_W'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_pixel    <= pixel;
      a_row      <= row_pos;
      a_col      <= col_pos;
      a_last_row <= last_row_in;
      a_last_col <= last_col_in;
      fwd_data   <= {above1, a_pixel};
    end

    if (issue) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PROD_W'(taps[i][j]) * PROD_W'(coefs[i][j]);
        end
      end
      p_row  <= job_sel[1] ? a_row : a_row - ROW_W'(1);
      p_col  <= job_sel[0] ? a_col : a_col - COL_W'(1);
      p_last <= (mask_rest == '0);
      p_done <= (mask_rest == '0) && a_last_row && a_last_col;
    end

    if (p_valid) begin
      for (int i = 0; i < 3; i++) begin
        q_sum[i] <= SUM3_W'(prod[i][0]) + SUM3_W'(prod[i][1]) + SUM3_W'(prod[i][2]);
      end
      q_row  <= p_row;
      q_col  <= p_col;
      q_last <= p_last;
      q_done <= p_done;
    end

    if (push) begin
      fifo[wptr].filtered <= sat_val;
      fifo[wptr].row      <= q_row;
      fifo[wptr].col      <= q_col;
      fifo[wptr].last     <= q_last;
      fifo[wptr].done     <= q_done;
    end
  end

endmodule

[src/c3x3_check.sv]
// port-level checker for the streaming 3x3 convolution, bound to the top level
module c3x3_check #(
  parameter int ROW_W = 12,
  parameter int COL_W = 8
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [c3x3_pkg::PIX_W-1:0] filtered,
  input logic [ROW_W-1:0]                  out_row,
  input logic [COL_W-1:0]                  out_col,
  input logic                              last,
  input logic                              frame_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered) && $stable(out_row) &&
      $stable(out_col) && $stable(last) && $stable(frame_done))
    else $error("stalled result word changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last)
    else $error("frame_done on a word that is not last");

  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind conv3x3_stream_const_pad c3x3_check #(.ROW_W(ROW_W), .COL_W(COL_W)) u_check (.*);

[test/conv3x3_checker.sv]
`timescale 1ns / 100ps
// checker for the 3x3 convolution: tracks registers, predicts filtered words and compares them
module conv3x3_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [c3x3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [c3x3_pkg::COEFF_REG_W-1:0]    cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [c3x3_pkg::PIX_W-1:0]          pixel,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [c3x3_pkg::PIX_W-1:0]          filtered,
  input  logic [$clog2(c3x3_pkg::DEF_MAX_HEIGHT)-1:0] out_row,
  input  logic [$clog2(c3x3_pkg::DEF_MAX_WIDTH)-1:0]  out_col,
  input  logic                                last,
  input  logic                                frame_done,
  output int                                  fail_count,
  output int                                  words_pending
);
  import c3x3_pkg::*;

  localparam int ROW_BITS = $clog2(DEF_MAX_HEIGHT);
  localparam int COL_BITS = $clog2(DEF_MAX_WIDTH);

  typedef struct packed {
    logic [PIX_W-1:0]    value;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
    logic                done;
  } conv_word_t;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [COEFF_REG_W-1:0]  kernel_r [3];
  logic [PIX_W-1:0]        older_mem [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]        newer_mem [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]        win [6];
  int                      row_q;
  int                      col_q;
  int                      grid [4][4];
  conv_word_t              pending_words [$];
  conv_word_t              got;
  conv_word_t              want;

  function automatic int pix_value(input logic [PIX_W-1:0] v);
    return int'($signed(v));
  endfunction

  function automatic int kernel_tap(input int i, input int j);
    return int'($signed(kernel_r[i][16*j +: 16]));
  endfunction

  // 3x3 window of the grid at top-left (i0, j0), floor to Q8.8 and saturate
  function automatic logic [PIX_W-1:0] window_conv(input int i0, input int j0);
    longint acc;
    longint q;
    int i;
    int j;
    acc = 0;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        acc += longint'(grid[i0 + i][j0 + j]) * longint'(kernel_tap(i, j));
    q = acc >>> FRAC_SHIFT;
    if (q > longint'(PIX_MAX)) q = longint'(PIX_MAX);
    if (q < longint'(PIX_MIN)) q = longint'(PIX_MIN);
    return q[PIX_W-1:0];
  endfunction

  task automatic filter_pixel(input logic [PIX_W-1:0] px);
    int r;
    int c;
    int n;
    int seen;
    int i;
    int j;
    int k;
    bit last_c;
    bit last_r;
    bit take [4];
    logic [PIX_W-1:0] above2;
    logic [PIX_W-1:0] above1;
    conv_word_t w;
    r = row_q;
    c = col_q;
    last_c = (c + 1 >= int'(width_r)) || (c >= DEF_MAX_WIDTH - 1);
    last_r = (r + 1 >= int'(height_r)) || (r >= DEF_MAX_HEIGHT - 1);
    above2 = older_mem[c];
    above1 = newer_mem[c];
    for (i = 0; i < 3; i++) begin
      grid[i][0] = pix_value(win[3 + i]);
      grid[i][1] = pix_value(win[i]);
    end
    grid[0][2] = pix_value(above2);
    grid[1][2] = pix_value(above1);
    grid[2][2] = pix_value(px);
    for (i = 0; i < 4; i++) begin
      grid[i][3] = int'(PAD_ONE);
      grid[3][i] = int'(PAD_ONE);
    end
    for (j = 0; j < 4; j++) begin
      if (r < 2) grid[0][j] = int'(PAD_ONE);
      if (r < 1) grid[1][j] = int'(PAD_ONE);
    end
    for (i = 0; i < 4; i++) begin
      if (c < 2) grid[i][0] = int'(PAD_ONE);
      if (c < 1) grid[i][1] = int'(PAD_ONE);
    end
    // upper-left, upper-right, lower-left, lower-right neighbours of the window
    take[0] = (r >= 1) && (c >= 1);
    take[1] = (r >= 1) && last_c;
    take[2] = last_r && (c >= 1);
    take[3] = last_r && last_c;
    n = 0;
    for (k = 0; k < 4; k++) if (take[k]) n++;
    seen = 0;
    for (k = 0; k < 4; k++) begin
      if (take[k]) begin
        seen++;
        w.value = window_conv(k / 2, k % 2);
        w.row   = ROW_BITS'(r - 1 + k / 2);
        w.col   = COL_BITS'(c - 1 + k % 2);
        w.last  = (seen == n);
        w.done  = (seen == n) && last_r && last_c;
        pending_words.push_back(w);
      end
    end
    for (i = 0; i < 3; i++) win[3 + i] = win[i];
    win[0] = above2;
    win[1] = above1;
    win[2] = px;
    older_mem[c] = above1;
    newer_mem[c] = px;
    if (last_c) begin
      col_q = 0;
      row_q = last_r ? 0 : r + 1;
    end else begin
      col_q = c + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_r  = RST_FRAME_WIDTH;
      height_r = RST_FRAME_HEIGHT;
      for (int i = 0; i < 3; i++) kernel_r[i] = RST_COEFF_ROW;
      for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
        older_mem[i] = '0;
        newer_mem[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      row_q = 0;
      col_q = 0;
      fail_count = 0;
      pending_words.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_r = cfg_data[WIDTH_REG_W-1:0];
          REG_FRAME_HEIGHT: height_r = cfg_data[HEIGHT_REG_W-1:0];
          REG_COEFF_TOP:    kernel_r[0] = cfg_data;
          REG_COEFF_MID:    kernel_r[1] = cfg_data;
          REG_COEFF_BOT:    kernel_r[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) filter_pixel(pixel);
      if (out_valid && !out_stall) begin
        got = '{filtered, out_row, out_col, last, frame_done};
        if (pending_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, actual value %h row %0d col %0d last %b done %b",
                   $time, got.value, got.row, got.col, got.last, got.done);
        end else begin
          want = pending_words.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: word mismatch, expected value %h row %0d col %0d last %b done %b",
                     $time, want.value, want.row, want.col, want.last, want.done);
            $display("%0t:                  actual value %h row %0d col %0d last %b done %b",
                     $time, got.value, got.row, got.col, got.last, got.done);
          end
        end
      end
    end
    words_pending = pending_words.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// top of the 3x3 convolution testbench: clock, reset, frame stimulus and verdict
module tb_top;
  import c3x3_pkg::*;

  localparam int ROW_BITS     = $clog2(DEF_MAX_HEIGHT);
  localparam int COL_BITS     = $clog2(DEF_MAX_WIDTH);
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 10;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_ITEMS = 200;
  localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [COEFF_REG_W-1:0]    cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [PIX_W-1:0]   pixel = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [PIX_W-1:0]   filtered;
  logic [ROW_BITS-1:0]       out_row;
  logic [COL_BITS-1:0]       out_col;
  logic                      last;
  logic                      frame_done;
  int                        fail_count;
  int                        words_pending;
  int                        idle_pct = 0;
  int                        stall_pct = 0;
  int                        items_done = 0;

  conv3x3_stream_const_pad i_dut (.*);

  conv3x3_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0: return PIX_MAX;
      1: return PIX_MIN;
      2: return '0;
      3: return PAD_ONE;
      4, 5: return 16'($urandom_range(4095)) - 16'h0800;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_tap();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h1000;
      4, 5: return 16'($urandom_range(8191)) - 16'h1000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [COEFF_REG_W-1:0] random_kernel_row();
    return {random_tap(), random_tap(), random_tap()};
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] px);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    pixel <= px;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_done++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COEFF_REG_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  // size registers carry random upper bits, which the block must ignore
  task automatic set_frame(input int w, input int h, input logic [COEFF_REG_W-1:0] top,
                           input logic [COEFF_REG_W-1:0] mid, input logic [COEFF_REG_W-1:0] bot);
    logic [COEFF_REG_W-1:0] wd;
    logic [COEFF_REG_W-1:0] hd;
    wd = COEFF_REG_W'({$urandom, $urandom});
    hd = COEFF_REG_W'({$urandom, $urandom});
    wd[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w);
    hd[HEIGHT_REG_W-1:0] = HEIGHT_REG_W'(h);
    drain();
    write_reg(REG_FRAME_WIDTH, wd);
    write_reg(REG_FRAME_HEIGHT, hd);
    write_reg(REG_COEFF_TOP, top);
    write_reg(REG_COEFF_MID, mid);
    write_reg(REG_COEFF_BOT, bot);
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, COEFF_REG_W'({$urandom, $urandom}));
    cfg_write <= 1'b0;
  endtask

  task automatic send_frame(input int w, input int h);
    int ew;
    int eh;
    ew = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
    eh = (h == 0) ? 1 : ((h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h);
    repeat (ew * eh) push_pixel(random_pixel());
  endtask

  task automatic run_phase(input int idle, input int stall);
    int start;
    int w;
    int h;
    bit first;
    idle_pct = idle;
    stall_pct = stall;
    start = items_done;
    first = 1'b1;
    while (items_done - start < PHASE_ITEMS) begin
      if (first || $urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0: w = 0;
          1, 2: w = $urandom_range(24, 9);
          default: w = $urandom_range(8, 1);
        endcase
        h = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
        set_frame(w, h, random_kernel_row(), random_kernel_row(), random_kernel_row());
        first = 1'b0;
      end
      send_frame(w, h);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // mixed extreme kernel over a 3x3 frame
    set_frame(3, 3, {16'h1000, 16'h8000, 16'h7FFF}, {16'h0000, 16'h1000, 16'h0000},
              {16'h7FFF, 16'h8000, 16'hFFFF});
    push_pixel(PIX_MAX);
    push_pixel(PIX_MIN);
    push_pixel(16'h0000);
    push_pixel(16'hFFFF);
    push_pixel(PAD_ONE);
    push_pixel(PIX_MAX);
    push_pixel(PIX_MIN);
    push_pixel(16'h0001);
    push_pixel(PIX_MAX);
    // single-pixel frames, also with zero sizes
    set_frame(1, 1, RST_COEFF_ROW, RST_COEFF_ROW, RST_COEFF_ROW);
    push_pixel(PIX_MIN);
    set_frame(0, 0, {3{16'h1000}}, {3{16'h1000}}, {3{16'h1000}});
    push_pixel(PIX_MAX);
    // saturation both ways
    set_frame(2, 2, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    repeat (4) push_pixel(PIX_MAX);
    set_frame(4, 1, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    repeat (4) push_pixel(PIX_MAX);

    run_phase(0, 0);
    run_phase(87, 0);
    run_phase(0, 87);
    run_phase(10, 10);

    stall_pct = 0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
